// ===== design/kst_pkg.sv =====
// shared types and codes for the keyed settings table
package kst_pkg;

   localparam logic [1:0] MODE_GET   = 2'd0;
   localparam logic [1:0] MODE_PUT   = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam logic [2:0] ST_NONE      = 3'd0;
   localparam logic [2:0] ST_REJECTED  = 3'd1;
   localparam logic [2:0] ST_UNCHANGED = 3'd2;
   localparam logic [2:0] ST_UPDATED   = 3'd3;
   localparam logic [2:0] ST_INSERTED  = 3'd4;
   localparam logic [2:0] ST_EVICTED   = 3'd5;

   typedef struct packed {
      logic [1:0]         mode;
      logic [63:0]        key;
      logic signed [31:0] new_volume;
      logic               new_muted;
      logic signed [31:0] new_latency;
      logic [63:0]        new_name_tag;
   } req_type;

   typedef struct packed {
      logic [63:0]        key;
      logic signed [31:0] volume;
      logic               muted;
      logic signed [15:0] latency;
      logic [63:0]        name_tag;
      logic [31:0]        order;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   typedef struct packed {
      logic               found;
      logic signed [31:0] stored_volume;
      logic               stored_muted;
      logic signed [15:0] stored_latency;
      logic [63:0]        stored_name_tag;
      logic [2:0]         put_status;
      logic [63:0]        victim_key;
   } res_type;

endpackage

// ===== design/kst_ram.sv =====
// generic single-port-write, registered-read ram
module kst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/kst_ctrl.sv =====
// request sequencer: valid bits, table scan, decision and write-back
module kst_ctrl #(
   parameter int ENTRIES = 32,
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  kst_pkg::req_type      req,
   output logic                  rd_en,
   output logic [IDX_W-1:0]      rd_addr,
   input  logic [kst_pkg::REC_W-1:0] rd_data,
   output logic                  wr_en,
   output logic [IDX_W-1:0]      wr_addr,
   output logic [kst_pkg::REC_W-1:0] wr_data,
   input  logic                  out_free,
   output logic                  push,
   output kst_pkg::res_type      res
);
   import kst_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DRAIN  = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_OUT    = 3'd4;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   logic [2:0]         state_ff, state_in;
   logic [IDX_W-1:0]   cnt_ff, cnt_in;
   logic               chk_ff, chk_in;
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   req_type            req_ff, req_in;
   logic signed [15:0] lat_ff, lat_in;
   logic               match_ff, match_in;
   logic [IDX_W-1:0]   match_idx_ff, match_idx_in;
   rec_type            hit_ff, hit_in;
   logic               free_ff, free_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic [31:0]        old_ord_ff, old_ord_in;
   logic [IDX_W-1:0]   old_idx_ff, old_idx_in;
   logic [63:0]        old_key_ff, old_key_in;
   res_type            res_ff, res_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [31:0]        wcnt_ff, wcnt_in;

   rec_type            rd_rec;
   rec_type            wr_rec;
   logic               accept;
   logic               same_data;
   logic [IDX_W-1:0]   slot;

   function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
      logic signed [15:0] r;
      if (v > 32'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -32'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   assign rd_rec    = rec_type'(rd_data);
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign same_data = (hit_ff.muted == req_ff.new_muted) && (hit_ff.latency == lat_ff)
                   && (hit_ff.volume == req_ff.new_volume)
                   && (hit_ff.name_tag == req_ff.new_name_tag);
   assign wr_data   = REC_W'(wr_rec);
   assign res       = res_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      chk_in       = chk_ff;
      chk_idx_in   = chk_idx_ff;
      req_in       = req_ff;
      lat_in       = lat_ff;
      match_in     = match_ff;
      match_idx_in = match_idx_ff;
      hit_in       = hit_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      old_ord_in   = old_ord_ff;
      old_idx_in   = old_idx_ff;
      old_key_in   = old_key_ff;
      res_in       = res_ff;
      valid_in     = valid_ff;
      wcnt_in      = wcnt_ff;
      rd_en        = 1'b0;
      rd_addr      = cnt_ff;
      wr_en        = 1'b0;
      slot         = match_idx_ff;
      push         = 1'b0;
      wr_rec.key      = req_ff.key;
      wr_rec.volume   = req_ff.new_volume;
      wr_rec.muted    = req_ff.new_muted;
      wr_rec.latency  = lat_ff;
      wr_rec.name_tag = req_ff.new_name_tag;
      wr_rec.order    = wcnt_ff + 32'd1;

      // results of the read issued in the previous cycle
      if (chk_ff) begin
         if (valid_ff[chk_idx_ff] && (rd_rec.key == req_ff.key) && !match_ff) begin
            match_in     = 1'b1;
            match_idx_in = chk_idx_ff;
            hit_in       = rd_rec;
         end
         if (!valid_ff[chk_idx_ff] && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = chk_idx_ff;
         end
         if ((chk_idx_ff == '0) || (rd_rec.order < old_ord_ff)) begin
            old_ord_in = rd_rec.order;
            old_idx_in = chk_idx_ff;
            old_key_in = rd_rec.key;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in   = req;
               lat_in   = sat16(req.new_latency);
               cnt_in   = '0;
               chk_in   = 1'b0;
               match_in = 1'b0;
               free_in  = 1'b0;
               res_in   = '0;
               state_in = S_OUT;
               case (req.mode)
                  MODE_GET: begin
                     if (req.key != 64'd0) begin
                        state_in = S_SCAN;
                     end
                  end
                  MODE_PUT: begin
                     if (req.key != 64'd0) begin
                        state_in = S_SCAN;
                     end else begin
                        res_in.put_status = ST_REJECTED;
                     end
                  end
                  MODE_CLEAR: begin
                     valid_in = '0;
                  end
                  default: begin
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_SCAN: begin
            rd_en      = 1'b1;
            rd_addr    = cnt_ff;
            chk_in     = 1'b1;
            chk_idx_in = cnt_ff;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            chk_in   = 1'b0;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            res_in   = '0;
            state_in = S_OUT;
            if (req_ff.mode == MODE_GET) begin
               if (match_ff) begin
                  res_in.found           = 1'b1;
                  res_in.stored_volume   = hit_ff.volume;
                  res_in.stored_muted    = hit_ff.muted;
                  res_in.stored_latency  = hit_ff.latency;
                  res_in.stored_name_tag = hit_ff.name_tag;
               end
            end else begin
               if (match_ff && same_data) begin
                  res_in.put_status = ST_UNCHANGED;
               end else begin
                  if (match_ff) begin
                     slot              = match_idx_ff;
                     res_in.put_status = ST_UPDATED;
                  end else if (free_ff) begin
                     slot              = free_idx_ff;
                     res_in.put_status = ST_INSERTED;
                  end else begin
                     slot              = old_idx_ff;
                     res_in.put_status = ST_EVICTED;
                     res_in.victim_key = old_key_ff;
                  end
                  wr_en          = 1'b1;
                  wcnt_in        = wcnt_ff + 32'd1;
                  valid_in[slot] = 1'b1;
               end
            end
         end
         S_OUT: begin
            push = out_free;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign wr_addr = slot;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         chk_ff   <= 1'b0;
         valid_ff <= '0;
         wcnt_ff  <= 32'd0;
         match_ff <= 1'b0;
         free_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         chk_ff   <= chk_in;
         valid_ff <= valid_in;
         wcnt_ff  <= wcnt_in;
         match_ff <= match_in;
         free_ff  <= free_in;
      end
      cnt_ff       <= cnt_in;
      chk_idx_ff   <= chk_idx_in;
      req_ff       <= req_in;
      lat_ff       <= lat_in;
      match_idx_ff <= match_idx_in;
      hit_ff       <= hit_in;
      free_idx_ff  <= free_idx_in;
      old_ord_ff   <= old_ord_in;
      old_idx_ff   <= old_idx_in;
      old_key_ff   <= old_key_in;
      res_ff       <= res_in;
   end

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (accept && (req.mode == MODE_CLEAR)) |=> (valid_ff == '0))
      else $error("clear left valid entries");

   a_count_on_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (wcnt_ff == $past(wcnt_ff) + 32'd1))
      else $error("write counter missed a table write");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !wr_en |=> $stable(wcnt_ff))
      else $error("write counter moved without a table write");

   a_evict_when_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && !match_ff && !free_ff) |-> (&valid_ff))
      else $error("eviction chosen while a slot is free");

   a_no_scan_overlap: assert property (@(posedge clock) disable iff (reset)
      (wr_en || push) |-> !chk_ff)
      else $error("write-back or response during a scan");

endmodule

// ===== design/keyed_settings_table_oldest_eviction_core.sv =====
// top level of the keyed settings table with oldest-first replacement
//
//  channel | direction | accepted when             | carries
//  req_    | in        | req_tvalid & req_tready   | mode, key, new record
//  rsp_    | out       | rsp_tvalid & rsp_tready   | lookup data, put status
//
// a request with a nonzero key for get or put scans the table, one entry per
// cycle through the record ram read port, then decides and writes back
// clear, mode 3 and key 0 skip the scan and go straight to the response
// reset empties the table at once through per-entry valid bits, no sweep
// one result waits in the output register while the next request is taken
// a stalled response holds the sequencer only when a second result is ready
module keyed_settings_table_oldest_eviction_core #(
   parameter int ENTRIES = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // key, new_volume, new_muted, new_latency, new_name_tag, zero fill
   input  logic [199:0] req_tdata,
   // mode
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // stored_volume, stored_muted, stored_latency, stored_name_tag, victim_key,
   // zero fill
   output logic [183:0] rsp_tdata,
   // found, put_status
   output logic [3:0]   rsp_tuser
);
   import kst_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   req_type            req;
   res_type            res;
   res_type            rsp_ff;
   logic               rsp_valid_ff;
   logic               out_free;
   logic               push;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [REC_W-1:0]   rd_data;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [REC_W-1:0]   wr_data;

   assign req.mode         = req_tuser;
   assign req.key          = req_tdata[63:0];
   assign req.new_volume   = req_tdata[95:64];
   assign req.new_muted    = req_tdata[96];
   assign req.new_latency  = req_tdata[128:97];
   assign req.new_name_tag = req_tdata[192:129];

   kst_ram #(
      .WIDTH (REC_W),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   kst_ctrl #(
      .ENTRIES (ENTRIES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .out_free  (out_free),
      .push      (push),
      .res       (res)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= push;
      end
      if (push) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff.victim_key, rsp_ff.stored_name_tag,
                        rsp_ff.stored_latency, rsp_ff.stored_muted,
                        rsp_ff.stored_volume};
   assign rsp_tuser  = {rsp_ff.put_status, rsp_ff.found};

endmodule
